FILE: sv/fwdf_pkg.sv
// shared constants and types for the fixed-width decimal formatter
`timescale 1ns / 1ps

package fwdf_pkg;

  localparam int VALUE_W     = 32;
  localparam int WIDTH_W     = 5;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  // a 32-bit magnitude never needs more than ten decimal digits
  localparam int DIGITS      = 10;
  localparam int DIGIT_IDX_W = $clog2(DIGITS);
  localparam int SHIFT_CNT_W = $clog2(VALUE_W);
  localparam int MAX_WIDTH_DEF = 16;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_PLUS  = 8'h2B;
  localparam char_t CHAR_MINUS = 8'h2D;

endpackage

FILE: sv/fwdf_if.sv
// valid/ready channel interfaces for the formatter input and character output
`timescale 1ns / 1ps

interface fwdf_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [fwdf_pkg::VALUE_W-1:0]    value;
  logic [fwdf_pkg::WIDTH_W-1:0]    width;

  modport source (output valid, output func, output value, output width, input ready);
  modport sink (input valid, input func, input value, input width, output ready);
endinterface

interface fwdf_out_if;
  logic                  valid;
  logic                  ready;
  fwdf_pkg::char_t       ascii_char;
  logic                  last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink (input valid, input ascii_char, input last, output ready);
endinterface

FILE: sv/fwdf_dabble.sv
// bit-serial binary to bcd converter, shift-and-add-3, one input bit per cycle
`timescale 1ns / 1ps

module fwdf_dabble (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fwdf_pkg::VALUE_W-1:0]  mag,
  output logic                          done,
  output fwdf_pkg::digit_t              digits [fwdf_pkg::DIGITS]
);

  localparam int CNTW = fwdf_pkg::SHIFT_CNT_W;

  logic [fwdf_pkg::VALUE_W-1:0] sh_r;
  logic [CNTW-1:0]              cnt_r;
  logic                         busy_r;
  logic                         done_r;
  fwdf_pkg::digit_t             dig_r   [fwdf_pkg::DIGITS];
  fwdf_pkg::digit_t             adj     [fwdf_pkg::DIGITS];
  fwdf_pkg::digit_t             dig_nxt [fwdf_pkg::DIGITS];

  // add 3 to any digit of 5 or more, then shift the whole bcd word left by one
  always_comb begin
    for (int i = 0; i < fwdf_pkg::DIGITS; i++) begin
      adj[i] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
    dig_nxt[0] = {adj[0][2:0], sh_r[fwdf_pkg::VALUE_W-1]};
    for (int i = 1; i < fwdf_pkg::DIGITS; i++) begin
      dig_nxt[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNTW'(fwdf_pkg::VALUE_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(fwdf_pkg::VALUE_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r <= mag;
      for (int i = 0; i < fwdf_pkg::DIGITS; i++) begin
        dig_r[i] <= '0;
      end
    end else if (busy_r) begin
      sh_r <= {sh_r[fwdf_pkg::VALUE_W-2:0], 1'b0};
      for (int i = 0; i < fwdf_pkg::DIGITS; i++) begin
        dig_r[i] <= dig_nxt[i];
      end
    end
  end

  assign done   = done_r;
  assign digits = dig_r;

endmodule

FILE: sv/fixed_width_decimal_formatter_unit.sv
// Fixed-width decimal formatter: each input transaction (func, value, width) yields
// width ASCII characters, most significant first, zero padded, keeping only the low
// digits when the number is longer than the field; in signed mode the first character
// is replaced by '-' or '+'. A width above MAX_WIDTH is clamped to MAX_WIDTH, and a
// width of zero yields nothing and leaves the input ready. One item is worked at a time:
// the magnitude goes through a bit-serial binary-to-BCD shift loop, then one character
// per cycle leaves through the output register while the output is not stalled.
`timescale 1ns / 1ps

module fixed_width_decimal_formatter_unit #(
  parameter int MAX_WIDTH = fwdf_pkg::MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  fwdf_in_if.sink           in_ch,
  fwdf_out_if.source        out_ch
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > fwdf_pkg::WIDTH_W) ? CW : fwdf_pkg::WIDTH_W;
  localparam int IW = fwdf_pkg::DIGIT_IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                        state_r;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 pos_r;
  logic                          func_r;
  logic                          neg_r;
  logic                          out_valid_r;
  fwdf_pkg::char_t               out_char_r;
  logic                          out_last_r;

  logic                          in_acc;
  logic [EW-1:0]                 width_ext;
  logic [CW-1:0]                 count_in;
  logic                          neg_in;
  logic [fwdf_pkg::VALUE_W-1:0]  mag_in;
  logic                          dd_start;
  logic                          dd_done;
  fwdf_pkg::digit_t              digits [fwdf_pkg::DIGITS];
  logic                          slot_free;
  logic                          load;
  logic [CW-1:0]                 idx;
  fwdf_pkg::digit_t              digit_sel;
  fwdf_pkg::char_t               char_sel;
  logic                          last_sel;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // clamp the requested width to MAX_WIDTH
  assign width_ext = EW'(in_ch.width);
  assign count_in  = (width_ext > EW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_ext);

  assign neg_in   = in_ch.func && in_ch.value[fwdf_pkg::VALUE_W-1];
  assign mag_in   = neg_in ? (~in_ch.value + 1'b1) : in_ch.value;
  assign dd_start = in_acc && (count_in != '0);

  fwdf_dabble u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dd_start),
    .mag    (mag_in),
    .done   (dd_done),
    .digits (digits)
  );

  assign slot_free = !out_valid_r || out_ch.ready;
  assign load      = (state_r == ST_EMIT) && slot_free;

  // character position pos_r shows digit number count-1-pos, zero above the tenth
  assign idx       = count_r - pos_r - CW'(1);
  assign digit_sel = (idx < CW'(fwdf_pkg::DIGITS)) ? digits[idx[IW-1:0]] : '0;
  assign last_sel  = (pos_r == count_r - CW'(1));

  always_comb begin
    char_sel = fwdf_pkg::CHAR_ZERO | {4'd0, digit_sel};
    if (func_r && (pos_r == '0)) begin
      char_sel = neg_r ? fwdf_pkg::CHAR_MINUS : fwdf_pkg::CHAR_PLUS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (dd_start) begin
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (dd_done) begin
            state_r <= ST_EMIT;
            pos_r   <= '0;
          end
        end
        ST_EMIT: begin
          if (load) begin
            pos_r <= pos_r + 1'b1;
            if (last_sel) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dd_start) begin
      count_r <= count_in;
      func_r  <= in_ch.func;
      neg_r   <= neg_in;
    end
    if (load) begin
      out_char_r <= char_sel;
      out_last_r <= last_sel;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ascii_char = out_char_r;
  assign out_ch.last       = out_last_r;

  // the last character of an item always frees the input
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load && last_sel |=> state_r == ST_IDLE)
    else $error("formatter did not return to idle after the last character");

  // position never runs past the clamped character count
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> pos_r < count_r)
    else $error("character position beyond count");

  // signed mode puts a sign in the first character
  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    load && func_r && pos_r == '0 |=>
      out_char_r == fwdf_pkg::CHAR_MINUS || out_char_r == fwdf_pkg::CHAR_PLUS)
    else $error("first character of a signed item is not a sign");

  // the converter only finishes while the controller waits for it
  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    dd_done |-> state_r == ST_CONV)
    else $error("converter finished outside the conversion phase");

endmodule
